/* hdl/lic_pkg.sv */
package lic_pkg;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 48;

  // derived widths
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DELTA_BITS;
  localparam int DEN_BITS   = PROD_BITS + 1;
  localparam int NUM_BITS   = DEN_BITS + DELTA_BITS + 1;
  localparam int DIVD_BITS  = NUM_BITS + FRAC_BITS;
  localparam int LO_BITS    = DEN_BITS / 2;
  localparam int HI_BITS    = DEN_BITS - LO_BITS;
  localparam int DIV_LAT    = OUT_BITS + 1;

  localparam logic [2:0] REL_PARALLEL = 3'd0;
  localparam logic [2:0] REL_WITHIN   = 3'd1;
  localparam logic [2:0] REL_FORWARD  = 3'd2;
  localparam logic [2:0] REL_BACKWARD = 3'd3;
  localparam logic [2:0] REL_MIXED    = 3'd4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_end_x;
    logic signed [COORD_BITS-1:0] a_end_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_end_x;
    logic signed [COORD_BITS-1:0] b_end_y;
  } lic_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] cross_x;
    logic signed [OUT_BITS-1:0] cross_y;
    logic [2:0]                 relation;
    logic                       overflow;
  } lic_out_t;

endpackage

/* hdl/lic_div.sv */
module lic_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [lic_pkg::DIVD_BITS-1:0]    dividend,
  input  logic [lic_pkg::DEN_BITS-1:0]     divisor,
  input  logic                             neg,
  output logic signed [lic_pkg::OUT_BITS-1:0] coord,
  output logic                             ovf
);
  import lic_pkg::*;

  localparam int EXT_BITS = DIVD_BITS + OUT_BITS;
  localparam logic [OUT_BITS-1:0] HALF = {1'b1, {(OUT_BITS-1){1'b0}}};

  // per stage: partial remainder, low dividend bits shifting out as quotient shifts in
  logic [DEN_BITS-1:0] rem [OUT_BITS+1];
  logic [OUT_BITS-1:0] lq  [OUT_BITS+1];
  logic [DEN_BITS-1:0] dv  [OUT_BITS+1];
  logic                sg  [OUT_BITS+1];
  logic                big [OUT_BITS+1];

  logic [EXT_BITS-1:0]  ext;
  logic [DIVD_BITS-1:0] top_part;

  assign ext      = EXT_BITS'(dividend);
  assign top_part = ext[EXT_BITS-1:OUT_BITS];

  // first stage: quotient at or above 2^OUT_BITS is flagged here
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= top_part[DEN_BITS-1:0];
      lq[0]  <= ext[OUT_BITS-1:0];
      dv[0]  <= divisor;
      sg[0]  <= neg;
      big[0] <= top_part >= DIVD_BITS'(divisor);
    end
  end

  for (genvar k = 0; k < OUT_BITS; k++) begin : g_step
    logic [DEN_BITS:0] trial;
    logic [DEN_BITS:0] diff;
    logic              ge;
    assign trial = {rem[k], lq[k][OUT_BITS-1]};
    assign diff  = trial - {1'b0, dv[k]};
    assign ge    = trial >= {1'b0, dv[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        lq[k+1]  <= {lq[k][OUT_BITS-2:0], ge};
        dv[k+1]  <= dv[k];
        sg[k+1]  <= sg[k];
        big[k+1] <= big[k];
      end
    end
  end

  // signed result with saturation
  logic [OUT_BITS-1:0] q;
  assign q = lq[OUT_BITS];

  always_comb begin
    ovf   = 1'b0;
    coord = '0;
    if (sg[OUT_BITS]) begin
      if (big[OUT_BITS] || q > HALF) begin
        ovf   = 1'b1;
        coord = HALF;
      end else begin
        coord = -q;
      end
    end else begin
      if (big[OUT_BITS] || q[OUT_BITS-1]) begin
        ovf   = 1'b1;
        coord = ~HALF;
      end else begin
        coord = q;
      end
    end
  end

endmodule

/* hdl/line_intersection_classify.sv */
// Intersection of two 2-D lines given by end points. Each beat carries the
// four end points; the result beat carries the meeting point of the infinite
// lines in signed fixed point (FRAC_BITS fraction bits, truncated toward
// zero, saturated with overflow set), plus a relation code: parallel,
// within both segments, both forward, both backward, or mixed. Parallel
// lines give a zero point. One beat is accepted every cycle while the output
// is not stalled; the result is formed by the restoring divider that
// produces one quotient bit per stage for each coordinate. A stalled output
// freezes the whole pipeline; no beat is dropped or repeated.
module line_intersection_classify (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  lic_pkg::lic_in_t  item,
  output logic              res_valid,
  input  logic              res_ready,
  output lic_pkg::lic_out_t res
);
  import lic_pkg::*;

  logic en;
  assign en         = !res_valid || res_ready;
  assign item_ready = en;

  // stage 1: differences
  logic                         v1;
  logic signed [DELTA_BITS-1:0] dax1, day1, dbx1, dby1, wx1, wy1;
  logic signed [COORD_BITS-1:0] ax1, ay1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dax1 <= DELTA_BITS'(item.a_end_x) - DELTA_BITS'(item.a_start_x);
      day1 <= DELTA_BITS'(item.a_end_y) - DELTA_BITS'(item.a_start_y);
      dbx1 <= DELTA_BITS'(item.b_end_x) - DELTA_BITS'(item.b_start_x);
      dby1 <= DELTA_BITS'(item.b_end_y) - DELTA_BITS'(item.b_start_y);
      wx1  <= DELTA_BITS'(item.a_start_x) - DELTA_BITS'(item.b_start_x);
      wy1  <= DELTA_BITS'(item.a_start_y) - DELTA_BITS'(item.b_start_y);
      ax1  <= item.a_start_x;
      ay1  <= item.a_start_y;
    end
  end

  // stage 2: the six cross products
  logic                         v2;
  logic signed [PROD_BITS-1:0]  p_dd0, p_dd1, p_t0, p_t1, p_s0, p_s1;
  logic signed [DELTA_BITS-1:0] dax2, day2;
  logic signed [COORD_BITS-1:0] ax2, ay2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_dd0 <= dby1 * dax1;
      p_dd1 <= dbx1 * day1;
      p_t0  <= dbx1 * wy1;
      p_t1  <= dby1 * wx1;
      p_s0  <= dax1 * wy1;
      p_s1  <= day1 * wx1;
      dax2  <= dax1;
      day2  <= day1;
      ax2   <= ax1;
      ay2   <= ay1;
    end
  end

  // stage 3: denominator and numerators
  logic                         v3;
  logic signed [DEN_BITS-1:0]   den3, tn3, sn3;
  logic signed [DELTA_BITS-1:0] dax3, day3;
  logic signed [COORD_BITS-1:0] ax3, ay3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den3 <= DEN_BITS'(p_dd0) - DEN_BITS'(p_dd1);
      tn3  <= DEN_BITS'(p_t0) - DEN_BITS'(p_t1);
      sn3  <= DEN_BITS'(p_s0) - DEN_BITS'(p_s1);
      dax3 <= dax2;
      day3 <= day2;
      ax3  <= ax2;
      ay3  <= ay2;
    end
  end

  // stage 4: partial products, den and tn split into signed high and unsigned low halves
  logic signed [HI_BITS-1:0]   den_hi, tn_hi;
  logic signed [LO_BITS:0]     den_lo, tn_lo;
  assign den_hi = den3[DEN_BITS-1:LO_BITS];
  assign tn_hi  = tn3[DEN_BITS-1:LO_BITS];
  assign den_lo = {1'b0, den3[LO_BITS-1:0]};
  assign tn_lo  = {1'b0, tn3[LO_BITS-1:0]};

  logic                                   v4;
  logic signed [COORD_BITS+HI_BITS-1:0]   xdh, ydh;
  logic signed [COORD_BITS+LO_BITS:0]     xdl, ydl;
  logic signed [HI_BITS+DELTA_BITS-1:0]   xth, yth;
  logic signed [LO_BITS+DELTA_BITS:0]     xtl, ytl;
  logic signed [DEN_BITS-1:0]             den4, tn4, sn4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xdh  <= ax3 * den_hi;
      xdl  <= ax3 * den_lo;
      xth  <= tn_hi * dax3;
      xtl  <= tn_lo * dax3;
      ydh  <= ay3 * den_hi;
      ydl  <= ay3 * den_lo;
      yth  <= tn_hi * day3;
      ytl  <= tn_lo * day3;
      den4 <= den3;
      tn4  <= tn3;
      sn4  <= sn3;
    end
  end

  // stage 5: numerators of the point and the relation code
  logic signed [DEN_BITS:0] nd, nt, ns;
  logic                     t_ge0, s_ge0, t_le1, s_le1;
  logic [2:0]               rel_next;

  always_comb begin
    nd = '0;
    nt = '0;
    ns = '0;
    if (den4[DEN_BITS-1]) begin
      nd = -(DEN_BITS+1)'(den4);
      nt = -(DEN_BITS+1)'(tn4);
      ns = -(DEN_BITS+1)'(sn4);
    end else begin
      nd = (DEN_BITS+1)'(den4);
      nt = (DEN_BITS+1)'(tn4);
      ns = (DEN_BITS+1)'(sn4);
    end
    t_ge0 = !nt[DEN_BITS];
    s_ge0 = !ns[DEN_BITS];
    t_le1 = t_ge0 && (nt <= nd);
    s_le1 = s_ge0 && (ns <= nd);
    if (t_le1 && s_le1) begin
      rel_next = REL_WITHIN;
    end else if (t_ge0 && s_ge0) begin
      rel_next = REL_FORWARD;
    end else if (!t_ge0 && !s_ge0) begin
      rel_next = REL_BACKWARD;
    end else begin
      rel_next = REL_MIXED;
    end
  end

  logic                       v5;
  logic signed [NUM_BITS-1:0] numx5, numy5;
  logic signed [DEN_BITS-1:0] den5;
  logic [2:0]                 rel5;
  logic                       par5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numx5 <= (NUM_BITS'(xdh) <<< LO_BITS) + NUM_BITS'(xdl)
             + (NUM_BITS'(xth) <<< LO_BITS) + NUM_BITS'(xtl);
      numy5 <= (NUM_BITS'(ydh) <<< LO_BITS) + NUM_BITS'(ydl)
             + (NUM_BITS'(yth) <<< LO_BITS) + NUM_BITS'(ytl);
      den5  <= den4;
      rel5  <= rel_next;
      par5  <= den4 == '0;
    end
  end

  // stage 6: magnitudes and signs for the dividers
  logic                 v6;
  logic [DIVD_BITS-1:0] nxa6, nya6;
  logic [DEN_BITS-1:0]  da6;
  logic                 negx6, negy6;
  logic [2:0]           rel6;
  logic                 par6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nxa6  <= DIVD_BITS'(numx5[NUM_BITS-1] ? -numx5 : numx5) << FRAC_BITS;
      nya6  <= DIVD_BITS'(numy5[NUM_BITS-1] ? -numy5 : numy5) << FRAC_BITS;
      da6   <= den5[DEN_BITS-1] ? -den5 : den5;
      negx6 <= numx5[NUM_BITS-1] ^ den5[DEN_BITS-1];
      negy6 <= numy5[NUM_BITS-1] ^ den5[DEN_BITS-1];
      rel6  <= rel5;
      par6  <= par5;
    end
  end

  // dividers, one quotient bit per stage
  logic signed [OUT_BITS-1:0] qx, qy;
  logic                       ox, oy;

  lic_div u_div_x (
    .clk      (clk),
    .en       (en),
    .dividend (nxa6),
    .divisor  (da6),
    .neg      (negx6),
    .coord    (qx),
    .ovf      (ox)
  );

  lic_div u_div_y (
    .clk      (clk),
    .en       (en),
    .dividend (nya6),
    .divisor  (da6),
    .neg      (negy6),
    .coord    (qy),
    .ovf      (oy)
  );

  // side band riding alongside the divider stages
  logic       dl_v   [DIV_LAT];
  logic [2:0] dl_rel [DIV_LAT];
  logic       dl_par [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dl_v[i] <= 1'b0;
      end
    end else if (en) begin
      dl_v[0] <= v6;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_v[i] <= dl_v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_rel[0] <= rel6;
      dl_par[0] <= par6;
      for (int i = 1; i < DIV_LAT; i++) begin
        dl_rel[i] <= dl_rel[i-1];
        dl_par[i] <= dl_par[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= dl_v[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dl_par[DIV_LAT-1]) begin
        res.cross_x  <= '0;
        res.cross_y  <= '0;
        res.relation <= REL_PARALLEL;
        res.overflow <= 1'b0;
      end else begin
        res.cross_x  <= qx;
        res.cross_y  <= qy;
        res.relation <= dl_rel[DIV_LAT-1];
        res.overflow <= ox | oy;
      end
    end
  end

  // parallel lines report a zero point and no overflow
  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.relation == REL_PARALLEL |->
      res.cross_x == '0 && res.cross_y == '0 && !res.overflow)
    else $error("parallel result with nonzero point");

  // overflow means at least one coordinate sits at a rail
  a_ovf_rail: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.overflow |->
      res.cross_x == {1'b1, {(OUT_BITS-1){1'b0}}} ||
      res.cross_x == {1'b0, {(OUT_BITS-1){1'b1}}} ||
      res.cross_y == {1'b1, {(OUT_BITS-1){1'b0}}} ||
      res.cross_y == {1'b0, {(OUT_BITS-1){1'b1}}})
    else $error("overflow without saturated coordinate");

endmodule

/* tb/line_intersection_classify_chk.sv */
`timescale 1ns / 100ps

module line_intersection_classify_chk (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  lic_pkg::lic_in_t  item,
  input  logic              res_valid,
  input  logic              res_ready,
  input  lic_pkg::lic_out_t res,
  output int                fail_count,
  output int                pending
);
  import lic_pkg::*;

  localparam logic signed [127:0] OUT_MAX = (128'sd1 <<< (OUT_BITS - 1)) - 1;
  localparam logic signed [127:0] OUT_MIN = -(128'sd1 <<< (OUT_BITS - 1));

  lic_out_t crossing_q[$];

  // one coordinate of the meeting point, truncated toward zero and clamped
  function automatic logic signed [OUT_BITS-1:0] meet_coord(
    input logic signed [127:0] base, input logic signed [127:0] delta,
    input logic signed [127:0] den, input logic signed [127:0] tn, inout logic ovf);
    logic signed [127:0] num;
    logic signed [127:0] q;
    num = (base * den + tn * delta) <<< FRAC_BITS;
    q = num / den;
    if (q > OUT_MAX) begin
      ovf = 1'b1;
      return OUT_MAX[OUT_BITS-1:0];
    end
    if (q < OUT_MIN) begin
      ovf = 1'b1;
      return OUT_MIN[OUT_BITS-1:0];
    end
    return q[OUT_BITS-1:0];
  endfunction

  function automatic lic_out_t classify_lines(input lic_in_t p);
    logic signed [127:0] ax, ay, bx, by, dax, day, dbx, dby, wx, wy;
    logic signed [127:0] den, tn, sn;
    logic ovf;
    lic_out_t r;
    ax = 128'(p.a_start_x);  ay = 128'(p.a_start_y);
    bx = 128'(p.b_start_x);  by = 128'(p.b_start_y);
    dax = 128'(p.a_end_x) - ax;  day = 128'(p.a_end_y) - ay;
    dbx = 128'(p.b_end_x) - bx;  dby = 128'(p.b_end_y) - by;
    wx = ax - bx;  wy = ay - by;
    den = dby * dax - dbx * day;
    tn = dbx * wy - dby * wx;
    sn = dax * wy - day * wx;
    r = '0;
    if (den == 0) return r;
    ovf = 1'b0;
    r.cross_x = meet_coord(ax, dax, den, tn, ovf);
    r.cross_y = meet_coord(ay, day, den, tn, ovf);
    r.overflow = ovf;
    if (den < 0) begin
      den = -den;  tn = -tn;  sn = -sn;
    end
    if (tn >= 0 && tn <= den && sn >= 0 && sn <= den) r.relation = REL_WITHIN;
    else if (tn >= 0 && sn >= 0) r.relation = REL_FORWARD;
    else if (tn < 0 && sn < 0) r.relation = REL_BACKWARD;
    else r.relation = REL_MIXED;
    return r;
  endfunction

  always @(posedge clk) begin
    lic_out_t want;
    if (rst) begin
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (item_valid && item_ready) crossing_q = {crossing_q, classify_lines(item)};
      if (res_valid && res_ready) begin
        if (crossing_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = crossing_q.pop_front();
          if (res.cross_x !== want.cross_x)
            $error("cross_x exp %0d got %0d", want.cross_x, res.cross_x);
          if (res.cross_y !== want.cross_y)
            $error("cross_y exp %0d got %0d", want.cross_y, res.cross_y);
          if (res.relation !== want.relation)
            $error("relation exp %0d got %0d", want.relation, res.relation);
          if (res.overflow !== want.overflow)
            $error("overflow exp %0d got %0d", want.overflow, res.overflow);
          if (res !== want) fail_count <= fail_count + 1;
        end
      end
      pending <= crossing_q.size();
    end
  end

endmodule

/* tb/line_intersection_classify_tb.sv */
`timescale 1ns / 100ps

module line_intersection_classify_tb;
  import lic_pkg::*;

  localparam int CMIN = -(1 << (COORD_BITS - 1));
  localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  lic_in_t item = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  lic_out_t res;
  int fail_count;
  int pending;

  // idle percentages for each side, changed per phase
  int send_idle = 0;
  int recv_stall = 0;
  // long output hold-off, counted down by the receiver process
  int hold_cycles = 0;

  always #5 clk = ~clk;

  line_intersection_classify i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  line_intersection_classify_chk i_chk (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stalls, or a long stretch held off
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(7))
      0: return COORD_BITS'(CMIN);
      1: return COORD_BITS'(CMAX);
      2: return COORD_BITS'(int'($urandom_range(15)) - 8);
      3: return COORD_BITS'(int'($urandom_range(2047)) - 1024);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic lic_in_t rand_pair();
    lic_in_t p;
    int kind;
    logic signed [COORD_BITS-1:0] dx, dy;
    p.a_start_x = rand_coord();  p.a_start_y = rand_coord();
    p.a_end_x = rand_coord();    p.a_end_y = rand_coord();
    p.b_start_x = rand_coord();  p.b_start_y = rand_coord();
    p.b_end_x = rand_coord();    p.b_end_y = rand_coord();
    kind = $urandom_range(9);
    // parallel lines: opposite direction on b
    if (kind == 0) begin
      dx = COORD_BITS'(int'($urandom_range(200)) - 100);
      dy = COORD_BITS'(int'($urandom_range(200)) - 100);
      p.a_end_x = p.a_start_x + dx;  p.a_end_y = p.a_start_y + dy;
      p.b_end_x = p.b_start_x - dx;  p.b_end_y = p.b_start_y - dy;
    end
    // degenerate: point for line a
    if (kind == 1) begin
      p.a_end_x = p.a_start_x;  p.a_end_y = p.a_start_y;
    end
    // nearly parallel, far meeting point to push saturation
    if (kind == 2) begin
      p.a_start_x = COORD_BITS'(CMIN);  p.a_end_x = COORD_BITS'(CMAX);
      p.a_start_y = '0;                 p.a_end_y = COORD_BITS'(1);
      p.b_start_x = COORD_BITS'(CMIN);  p.b_end_x = COORD_BITS'(CMAX);
      p.b_start_y = COORD_BITS'(5);
      p.b_end_y = COORD_BITS'(5 + int'($urandom_range(3)));
    end
    return p;
  endfunction

  task automatic send_beat(input lic_in_t p);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= p;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic mk_send(input int ax, input int ay, input int ex, input int ey,
                         input int bx, input int by, input int fx, input int fy);
    lic_in_t p;
    p.a_start_x = COORD_BITS'(ax);  p.a_start_y = COORD_BITS'(ay);
    p.a_end_x = COORD_BITS'(ex);    p.a_end_y = COORD_BITS'(ey);
    p.b_start_x = COORD_BITS'(bx);  p.b_start_y = COORD_BITS'(by);
    p.b_end_x = COORD_BITS'(fx);    p.b_end_y = COORD_BITS'(fy);
    send_beat(p);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: within, forward, mixed, parallel, degenerate, extremes
    mk_send(0, 0, 10, 10, 0, 10, 10, 0);
    mk_send(0, 0, 1, 1, 10, 0, 11, -1);
    mk_send(0, 0, -1, -1, 10, 0, 11, 1);
    mk_send(0, 0, 1, 0, 5, -5, 5, -6);
    mk_send(0, 0, 4, 4, 1, 0, 5, 4);
    mk_send(3, 3, 3, 3, 0, 0, 1, 2);
    mk_send(3, 3, 3, 3, 3, 3, 3, 3);
    mk_send(0, 0, 3, 1, 1, 0, 0, 7);
    mk_send(0, 0, -3, 1, 1, 0, 0, -7);
    mk_send(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
    mk_send(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN);
    mk_send(CMIN, 0, CMAX, 1, CMIN, 2, CMAX, 2);
    mk_send(CMIN, 0, CMAX, -1, CMIN, -2, CMAX, -2);
    mk_send(CMIN, 0, CMAX, 1, CMIN, 3, CMAX, 3);
    mk_send(-1, -1, -1, -1, -1, -1, -1, -1);
    mk_send(0, 0, 10, 0, 5, 0, 5, 10);
    mk_send(0, 0, 10, 0, 10, 0, 10, 10);
    mk_send(-7, 2, 9, -3, 4, 8, -6, -5);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 1 || phase == 3) ? (phase == 1 ? 71 : 38) : 0;
      recv_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 71 : 38) : 0;
      repeat (400) send_beat(rand_pair());
      // sender waits for every result before going on
      drain();
      if (phase == 0) begin
        // receiver holds off while the sender keeps offering beats
        hold_cycles = 300;
        repeat (150) send_beat(rand_pair());
        drain();
      end
    end

    drain();
    repeat (80) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
hdl/lic_pkg.sv
hdl/lic_div.sv
hdl/line_intersection_classify.sv
tb/line_intersection_classify_chk.sv
tb/line_intersection_classify_tb.sv
